// ===== rtl/core/psbg_pkg.sv =====
// ----------------------------------------------------------------------------
// PIE symbol burst generator package
// Shared widths, register map, command codes and segment length types.
// ----------------------------------------------------------------------------
package psbg_pkg;

    localparam int LENGTH_BITS   = 12;
    localparam int TIMER_BITS    = 24;
    localparam int SEG_BITS      = LENGTH_BITS + 1;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;

    // register map (word index)
    localparam logic [2:0] REG_DELIMITER   = 3'd0;
    localparam logic [2:0] REG_TARI        = 3'd1;
    localparam logic [2:0] REG_PULSE_WIDTH = 3'd2;
    localparam logic [2:0] REG_TRCAL       = 3'd3;
    localparam logic [2:0] REG_DATA1       = 3'd4;

    localparam logic [LENGTH_BITS-1:0] RST_DELIMITER   = LENGTH_BITS'(25);
    localparam logic [LENGTH_BITS-1:0] RST_TARI        = LENGTH_BITS'(25);
    localparam logic [LENGTH_BITS-1:0] RST_PULSE_WIDTH = LENGTH_BITS'(12);
    localparam logic [LENGTH_BITS-1:0] RST_TRCAL       = LENGTH_BITS'(100);
    localparam logic [LENGTH_BITS-1:0] RST_DATA1       = LENGTH_BITS'(38);

    // request operation and task commands
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_TASK = 1'b1;

    localparam logic [2:0] CMD_OFF      = 3'd0;
    localparam logic [2:0] CMD_ON       = 3'd1;
    localparam logic [2:0] CMD_TIMED    = 3'd2;
    localparam logic [2:0] CMD_PREAMBLE = 3'd3;
    localparam logic [2:0] CMD_FSYNC    = 3'd4;
    localparam logic [2:0] CMD_DATA     = 3'd5;

    // frame kinds
    localparam logic [1:0] KIND_PREAMBLE = 2'd0;
    localparam logic [1:0] KIND_FSYNC    = 2'd1;
    localparam logic [1:0] KIND_DATA0    = 2'd2;
    localparam logic [1:0] KIND_DATA1    = 2'd3;

    // segment positions; even segments are low, odd are high
    localparam logic [2:0] SEG_DELIM      = 3'd0;
    localparam logic [2:0] SEG_DATA       = 3'd1;
    localparam logic [2:0] SEG_RTCAL      = 3'd3;
    localparam logic [2:0] SEG_TRCAL      = 3'd5;
    localparam logic [2:0] SEG_LAST_PRE   = 3'd6;
    localparam logic [2:0] SEG_LAST_FSYNC = 3'd4;
    localparam logic [2:0] SEG_LAST_DATA  = 3'd2;

    typedef struct packed {
        logic [SEG_BITS-1:0] delim;
        logic [SEG_BITS-1:0] high_d0;
        logic [SEG_BITS-1:0] high_d1;
        logic [SEG_BITS-1:0] rtcal;
        logic [SEG_BITS-1:0] trcal;
        logic [SEG_BITS-1:0] pulse;
    } seg_len_t;

    typedef struct packed {
        logic sample;
        logic sample_valid;
        logic accepted;
        logic ready_res;
    } result_t;

endpackage

// ===== rtl/core/pie_symbol_burst_generator.sv =====
// ----------------------------------------------------------------------------
// PIE symbol burst generator
// Reader-side pulse-interval-encoding carrier sample generator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one request per cycle when
//   not stalled: a tick (operation 0) asks for one carrier sample, a task
//   (operation 1) sets the carrier off/on, starts a timed on-burst, or
//   sends a preamble, frame-sync or one PIE data bit. Every request yields
//   exactly one result on the output channel (out_valid/out_stall): sample,
//   sample_valid, accepted and ready_res.
//   A request accepted into the request register has its result captured
//   in the result register; throughput is one request per cycle while the
//   receiver does not stall, set by the combinational mode/segment update
//   between the request register and the result register.
//   When the receiver stalls, the result register holds; one more request
//   is captured, then in_stall rises until the result is taken.
//   Reset clears the pipeline and puts the carrier in off-idle; the timing
//   registers return to 25, 25, 12, 100, 38 samples. Registers are written
//   over APB and take effect at once.
// ----------------------------------------------------------------------------
module pie_symbol_burst_generator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [psbg_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [psbg_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [psbg_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 operation,
    input  logic [2:0]                           command,
    input  logic [psbg_pkg::TIMER_BITS-1:0]      duration,
    input  logic                                 bit_value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 sample,
    output logic                                 sample_valid,
    output logic                                 accepted,
    output logic                                 ready_res
);
    import psbg_pkg::*;

    seg_len_t seg_len;
    result_t  result;

    psbg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .seg_len (seg_len)
    );

    psbg_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_len   (seg_len),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .command   (command),
        .duration  (duration),
        .bit_value (bit_value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign sample       = result.sample;
    assign sample_valid = result.sample_valid;
    assign accepted     = result.accepted;
    assign ready_res    = result.ready_res;

endmodule

// ===== rtl/core/psbg_cfg.sv =====
// ----------------------------------------------------------------------------
// PIE symbol burst generator configuration registers
// APB register file for the timing lengths and the derived segment lengths.
// ----------------------------------------------------------------------------
module psbg_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [psbg_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [psbg_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [psbg_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    output psbg_pkg::seg_len_t                   seg_len
);
    import psbg_pkg::*;

    logic [LENGTH_BITS-1:0] delim_reg;
    logic [LENGTH_BITS-1:0] tari_reg;
    logic [LENGTH_BITS-1:0] pw_reg;
    logic [LENGTH_BITS-1:0] trcal_reg;
    logic [LENGTH_BITS-1:0] data1_reg;
    logic [2:0]             reg_idx;
    logic                   wr_en;
    logic [LENGTH_BITS-1:0] wr_val;
    logic [SEG_BITS-1:0]    rt_sum;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign wr_val  = pwdata[LENGTH_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= RST_DELIMITER;
            tari_reg  <= RST_TARI;
            pw_reg    <= RST_PULSE_WIDTH;
            trcal_reg <= RST_TRCAL;
            data1_reg <= RST_DATA1;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DELIMITER:   delim_reg <= wr_val;
                REG_TARI:        tari_reg  <= wr_val;
                REG_PULSE_WIDTH: pw_reg    <= wr_val;
                REG_TRCAL:       trcal_reg <= wr_val;
                REG_DATA1:       data1_reg <= wr_val;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DELIMITER:   prdata = APB_DATA_BITS'(delim_reg);
            REG_TARI:        prdata = APB_DATA_BITS'(tari_reg);
            REG_PULSE_WIDTH: prdata = APB_DATA_BITS'(pw_reg);
            REG_TRCAL:       prdata = APB_DATA_BITS'(trcal_reg);
            REG_DATA1:       prdata = APB_DATA_BITS'(data1_reg);
            default:         prdata = '0;
        endcase
    end

    // high segments saturate at zero
    function automatic logic [SEG_BITS-1:0] sat_sub(input logic [SEG_BITS-1:0] a,
                                                    input logic [SEG_BITS-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    assign rt_sum = SEG_BITS'(data1_reg) + SEG_BITS'(tari_reg);

    always_comb
    begin
        seg_len.delim   = SEG_BITS'(delim_reg);
        seg_len.high_d0 = sat_sub(SEG_BITS'(tari_reg), SEG_BITS'(pw_reg));
        seg_len.high_d1 = sat_sub(SEG_BITS'(data1_reg), SEG_BITS'(pw_reg));
        seg_len.rtcal   = sat_sub(rt_sum, SEG_BITS'(pw_reg));
        seg_len.trcal   = sat_sub(SEG_BITS'(trcal_reg), SEG_BITS'(pw_reg));
        seg_len.pulse   = SEG_BITS'(pw_reg);
    end

endmodule

// ===== rtl/core/psbg_core.sv =====
// ----------------------------------------------------------------------------
// PIE symbol burst generator core
// Request register, carrier mode and segment sequencer, result register.
// ----------------------------------------------------------------------------
module psbg_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  psbg_pkg::seg_len_t                seg_len,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic [2:0]                        command,
    input  logic [psbg_pkg::TIMER_BITS-1:0]   duration,
    input  logic                              bit_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output psbg_pkg::result_t                 result
);
    import psbg_pkg::*;

    typedef enum logic [2:0] {
        MODE_OFF,
        MODE_ON,
        MODE_TIMED,
        MODE_SEND,
        MODE_WAIT
    } mode_t;

    typedef struct packed {
        logic                found;
        logic [2:0]          seg;
        logic [SEG_BITS-1:0] len;
    } seg_pick_t;

    // request register
    logic                  in_vld_reg;
    logic                  op_reg;
    logic [2:0]            cmd_reg;
    logic [TIMER_BITS-1:0] dur_reg;
    logic                  bit_reg;

    // generator state
    mode_t                 mode_reg, mode_next;
    logic [1:0]            kind_reg, kind_next;
    logic [2:0]            seg_reg, seg_next;
    logic [TIMER_BITS-1:0] rem_reg, rem_next;

    // result register
    logic                  out_vld_reg;
    result_t               res_reg, res_next;

    logic                  advance;
    logic                  ready_now;
    logic                  is_task;
    logic [1:0]            srch_kind;
    logic [2:0]            srch_start;
    seg_pick_t             pick;
    logic [TIMER_BITS-1:0] rem_dec;

    function automatic logic [2:0] last_seg(input logic [1:0] kind);
        case (kind)
            KIND_PREAMBLE: return SEG_LAST_PRE;
            KIND_FSYNC:    return SEG_LAST_FSYNC;
            default:       return SEG_LAST_DATA;
        endcase
    endfunction

    function automatic logic [SEG_BITS-1:0] seg_length(input logic [1:0] kind,
                                                       input logic [2:0] s,
                                                       input seg_len_t   l);
        case (s)
            SEG_DELIM: return l.delim;
            SEG_DATA:  return (kind == KIND_DATA1) ? l.high_d1 : l.high_d0;
            SEG_RTCAL: return l.rtcal;
            SEG_TRCAL: return l.trcal;
            default:   return l.pulse;
        endcase
    endfunction

    // first non-empty segment at or after start, up to the frame's last
    function automatic seg_pick_t seg_search(input logic [1:0] kind,
                                             input logic [2:0] start,
                                             input seg_len_t   l);
        seg_pick_t           p;
        logic [2:0]          s;
        logic [SEG_BITS-1:0] n;
        p = '0;
        for (int i = 0; i <= int'(SEG_LAST_PRE); i++)
        begin
            s = 3'(i);
            n = seg_length(kind, s, l);
            if (!p.found && s >= start && s <= last_seg(kind) && n != '0)
            begin
                p.found = 1'b1;
                p.seg   = s;
                p.len   = n;
            end
        end
        return p;
    endfunction

    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign out_valid = out_vld_reg;
    assign result    = res_reg;

    assign ready_now = mode_reg inside {MODE_OFF, MODE_ON, MODE_WAIT};
    assign is_task   = (op_reg == OP_TASK);
    assign rem_dec   = (rem_reg != '0) ? (rem_reg - TIMER_BITS'(1)) : rem_reg;

    always_comb
    begin
        if (is_task)
        begin
            srch_kind  = (cmd_reg == CMD_PREAMBLE) ? KIND_PREAMBLE :
                         (cmd_reg == CMD_FSYNC)    ? KIND_FSYNC    :
                         (bit_reg ? KIND_DATA1 : KIND_DATA0);
            srch_start = (srch_kind[1]) ? SEG_DATA : SEG_DELIM;
        end
        else
        begin
            srch_kind  = kind_reg;
            srch_start = seg_reg + 3'd1;
        end
    end

    assign pick = seg_search(srch_kind, srch_start, seg_len);

    always_comb
    begin
        mode_next = mode_reg;
        kind_next = kind_reg;
        seg_next  = seg_reg;
        rem_next  = rem_reg;
        res_next  = '0;

        if (!is_task)
        begin
            case (mode_reg)
                MODE_OFF:
                begin
                    res_next.sample_valid = 1'b1;
                end
                MODE_ON:
                begin
                    res_next.sample       = 1'b1;
                    res_next.sample_valid = 1'b1;
                end
                MODE_TIMED:
                begin
                    res_next.sample       = 1'b1;
                    res_next.sample_valid = 1'b1;
                    rem_next              = rem_dec;
                    if (rem_dec == '0)
                    begin
                        mode_next = MODE_WAIT;
                    end
                end
                MODE_SEND:
                begin
                    res_next.sample       = seg_reg[0];
                    res_next.sample_valid = 1'b1;
                    rem_next              = rem_dec;
                    if (rem_dec == '0)
                    begin
                        if (pick.found)
                        begin
                            seg_next  = pick.seg;
                            rem_next  = TIMER_BITS'(pick.len);
                            mode_next = MODE_SEND;
                        end
                        else
                        begin
                            seg_next  = '0;
                            rem_next  = '0;
                            mode_next = MODE_WAIT;
                        end
                    end
                end
                default: ;
            endcase
        end
        else if (ready_now && (cmd_reg inside {[CMD_OFF:CMD_DATA]}))
        begin
            res_next.accepted = 1'b1;
            case (cmd_reg)
                CMD_OFF: mode_next = MODE_OFF;
                CMD_ON:  mode_next = MODE_ON;
                CMD_TIMED:
                begin
                    rem_next  = dur_reg;
                    mode_next = (dur_reg != '0) ? MODE_TIMED : MODE_WAIT;
                end
                default:
                begin
                    kind_next = srch_kind;
                    if (pick.found)
                    begin
                        seg_next  = pick.seg;
                        rem_next  = TIMER_BITS'(pick.len);
                        mode_next = MODE_SEND;
                    end
                    else
                    begin
                        seg_next  = '0;
                        rem_next  = '0;
                        mode_next = MODE_WAIT;
                    end
                end
            endcase
        end

        res_next.ready_res = mode_next inside {MODE_OFF, MODE_ON, MODE_WAIT};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            op_reg      <= OP_TICK;
            cmd_reg     <= CMD_OFF;
            dur_reg     <= '0;
            bit_reg     <= 1'b0;
            mode_reg    <= MODE_OFF;
            kind_reg    <= KIND_PREAMBLE;
            seg_reg     <= '0;
            rem_reg     <= '0;
            out_vld_reg <= 1'b0;
            res_reg     <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_vld_reg <= in_valid;
                if (in_valid)
                begin
                    op_reg  <= operation;
                    cmd_reg <= command;
                    dur_reg <= duration;
                    bit_reg <= bit_value;
                end
            end

            if (advance)
            begin
                mode_reg    <= mode_next;
                kind_reg    <= kind_next;
                seg_reg     <= seg_next;
                rem_reg     <= rem_next;
                out_vld_reg <= 1'b1;
                res_reg     <= res_next;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    a_send_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_SEND |-> rem_reg != '0)
        else $error("send segment with zero samples left");

    a_timed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_TIMED |-> rem_reg != '0)
        else $error("timed burst with zero samples left");

    a_seg_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_SEND |-> seg_reg <= last_seg(kind_reg))
        else $error("segment beyond end of frame");

    a_task_no_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> !(res_reg.sample_valid && res_reg.accepted))
        else $error("result both sample and accepted task");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_vld_reg && out_vld_reg && out_stall))
        else $error("input stalled without a blocked result");

endmodule

// ===== dv/pie_burst_checker.sv =====
// ----------------------------------------------------------------------------
// PIE burst checker
// Snoops the APB timing writes and both request/result channels, predicts
// the carrier result of every accepted request and compares field by field.
// ----------------------------------------------------------------------------
module pie_burst_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic                               pready,
    input  logic [psbg_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [psbg_pkg::APB_DATA_BITS-1:0] pwdata,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               operation,
    input  logic [2:0]                         command,
    input  logic [psbg_pkg::TIMER_BITS-1:0]    duration,
    input  logic                               bit_value,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic                               sample,
    input  logic                               sample_valid,
    input  logic                               accepted,
    input  logic                               ready_res,
    output int                                 fail_count,
    output int                                 pending
);
    import psbg_pkg::*;

    typedef enum logic [2:0] {
        CARRIER_OFF,
        CARRIER_ON,
        CARRIER_TIMED,
        CARRIER_SENDING,
        CARRIER_WAITING
    } carrier_mode_t;

    logic [LENGTH_BITS-1:0] delim_len;
    logic [LENGTH_BITS-1:0] tari_len;
    logic [LENGTH_BITS-1:0] pulse_len;
    logic [LENGTH_BITS-1:0] trcal_len;
    logic [LENGTH_BITS-1:0] data1_len;

    carrier_mode_t          mode;
    logic [1:0]             kind;
    logic [2:0]             seg;
    logic [TIMER_BITS-1:0]  seg_left;

    result_t                carrier_results[$];
    int                     mismatches;
    string                  field_name[4] = '{"ready_res", "accepted", "sample_valid", "sample"};

    function automatic logic [SEG_BITS-1:0] floor_sub(input logic [SEG_BITS-1:0] a,
                                                      input logic [SEG_BITS-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic logic [SEG_BITS-1:0] seg_span(input logic [1:0] k, input logic [2:0] s);
        case (s)
            SEG_DELIM: return SEG_BITS'(delim_len);
            SEG_DATA:  return floor_sub(SEG_BITS'((k == KIND_DATA1) ? data1_len : tari_len),
                                        SEG_BITS'(pulse_len));
            SEG_RTCAL: return floor_sub(SEG_BITS'(data1_len) + SEG_BITS'(tari_len),
                                        SEG_BITS'(pulse_len));
            SEG_TRCAL: return floor_sub(SEG_BITS'(trcal_len), SEG_BITS'(pulse_len));
            default:   return SEG_BITS'(pulse_len);
        endcase
    endfunction

    function automatic logic [2:0] last_seg(input logic [1:0] k);
        if (k == KIND_PREAMBLE)
            return SEG_LAST_PRE;
        if (k == KIND_FSYNC)
            return SEG_LAST_FSYNC;
        return SEG_LAST_DATA;
    endfunction

    function automatic logic carrier_idle();
        return mode == CARRIER_OFF || mode == CARRIER_ON || mode == CARRIER_WAITING;
    endfunction

    // first non-empty segment at or after first, else wait for the next task
    function automatic void seek_segment(input int first);
        int last;
        last = int'(last_seg(kind));
        for (int s = first; s <= last; s++) begin
            if (seg_span(kind, 3'(s)) != '0) begin
                seg      = 3'(s);
                seg_left = TIMER_BITS'(seg_span(kind, 3'(s)));
                mode     = CARRIER_SENDING;
                return;
            end
        end
        seg      = '0;
        seg_left = '0;
        mode     = CARRIER_WAITING;
    endfunction

    function automatic result_t next_carrier_result(input logic                  op,
                                                    input logic [2:0]            cmd,
                                                    input logic [TIMER_BITS-1:0] dur,
                                                    input logic                  bitv);
        result_t r;
        logic    idle_before;
        r           = '0;
        idle_before = carrier_idle();
        if (op == OP_TICK) begin
            case (mode)
                CARRIER_OFF:
                begin
                    r.sample_valid = 1'b1;
                end
                CARRIER_ON:
                begin
                    r.sample       = 1'b1;
                    r.sample_valid = 1'b1;
                end
                CARRIER_TIMED:
                begin
                    r.sample       = 1'b1;
                    r.sample_valid = 1'b1;
                    if (seg_left != '0)
                        seg_left = seg_left - 1'b1;
                    if (seg_left == '0)
                        mode = CARRIER_WAITING;
                end
                CARRIER_SENDING:
                begin
                    r.sample       = seg[0];
                    r.sample_valid = 1'b1;
                    if (seg_left != '0)
                        seg_left = seg_left - 1'b1;
                    if (seg_left == '0)
                        seek_segment(int'(seg) + 1);
                end
                default:
                begin
                end
            endcase
        end else if (idle_before && cmd <= CMD_DATA) begin
            r.accepted = 1'b1;
            case (cmd)
                CMD_OFF:
                    mode = CARRIER_OFF;
                CMD_ON:
                    mode = CARRIER_ON;
                CMD_TIMED:
                begin
                    seg_left = dur;
                    mode     = (dur != '0) ? CARRIER_TIMED : CARRIER_WAITING;
                end
                CMD_PREAMBLE:
                begin
                    kind = KIND_PREAMBLE;
                    seek_segment(int'(SEG_DELIM));
                end
                CMD_FSYNC:
                begin
                    kind = KIND_FSYNC;
                    seek_segment(int'(SEG_DELIM));
                end
                default:
                begin
                    kind = bitv ? KIND_DATA1 : KIND_DATA0;
                    seek_segment(int'(SEG_DATA));
                end
            endcase
        end
        r.ready_res = carrier_idle();
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n) begin
            delim_len  = RST_DELIMITER;
            tari_len   = RST_TARI;
            pulse_len  = RST_PULSE_WIDTH;
            trcal_len  = RST_TRCAL;
            data1_len  = RST_DATA1;
            mode       = CARRIER_OFF;
            kind       = KIND_PREAMBLE;
            seg        = '0;
            seg_left   = '0;
            mismatches = 0;
            carrier_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_BITS-1:2])
                    REG_DELIMITER:   delim_len = pwdata[LENGTH_BITS-1:0];
                    REG_TARI:        tari_len  = pwdata[LENGTH_BITS-1:0];
                    REG_PULSE_WIDTH: pulse_len = pwdata[LENGTH_BITS-1:0];
                    REG_TRCAL:       trcal_len = pwdata[LENGTH_BITS-1:0];
                    REG_DATA1:       data1_len = pwdata[LENGTH_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (out_valid && !out_stall) begin
                if (carrier_results.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatches++;
                end else begin
                    want = carrier_results.pop_front();
                    got  = {sample, sample_valid, accepted, ready_res};
                    for (int i = 0; i < 4; i++) begin
                        if (want[i] !== got[i]) begin
                            $error("%s: expected %0b, actual %0b", field_name[i], want[i], got[i]);
                            mismatches++;
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
                carrier_results.push_back(
                    next_carrier_result(operation, command, duration, bit_value));
        end
        fail_count <= mismatches;
        pending    <= carrier_results.size();
    end

endmodule

// ===== dv/pie_symbol_burst_generator_tb.sv =====
// ----------------------------------------------------------------------------
// PIE symbol burst generator testbench
// Drives tick and task requests with random gaps and result stalls across
// several timing register settings; the burst checker predicts and compares.
// ----------------------------------------------------------------------------
module pie_symbol_burst_generator_tb;

    import psbg_pkg::*;

    localparam logic [2:0] CMD_BAD_LO = 3'd6;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;
    localparam int         TIMED_MAX  = 12;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     operation = 1'b0;
    logic [2:0]               command = '0;
    logic [TIMER_BITS-1:0]    duration = '0;
    logic                     bit_value = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     sample;
    logic                     sample_valid;
    logic                     accepted;
    logic                     ready_res;

    int fail_count;
    int pending;
    int sent = 0;
    int stall_left = 0;
    bit send_steady = 1'b0;
    bit take_steady = 1'b0;

    int cfg_delim = 25;
    int cfg_tari  = 25;
    int cfg_pulse = 12;
    int cfg_trcal = 100;
    int cfg_data1 = 38;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pie_symbol_burst_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .command      (command),
        .duration     (duration),
        .bit_value    (bit_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample       (sample),
        .sample_valid (sample_valid),
        .accepted     (accepted),
        .ready_res    (ready_res)
    );

    pie_burst_checker carrier_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .command      (command),
        .duration     (duration),
        .bit_value    (bit_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample       (sample),
        .sample_valid (sample_valid),
        .accepted     (accepted),
        .ready_res    (ready_res),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // result side: a fresh stall count per result, with steady stretches
    always @(posedge clk)
    begin
        if (out_valid && !out_stall) begin
            if ($urandom_range(0, 15) == 0)
                take_steady = !take_steady;
            stall_left = take_steady ? 0 : $urandom_range(0, 10);
        end
        if (out_valid && stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic push_request(input logic op, input logic [2:0] cmd,
                                input logic [TIMER_BITS-1:0] dur, input logic bitv);
        int gap;
        if ($urandom_range(0, 15) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        command   <= cmd;
        duration  <= dur;
        bit_value <= bitv;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_request(OP_TICK, 3'($urandom), TIMER_BITS'($urandom), 1'($urandom));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input int val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_BITS'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_timing(input int d, input int t, input int p, input int tr,
                                  input int d1);
        drain();
        apb_write(REG_DELIMITER, d);
        apb_write(REG_TARI, t);
        apb_write(REG_PULSE_WIDTH, p);
        apb_write(REG_TRCAL, tr);
        apb_write(REG_DATA1, d1);
        cfg_delim = d;
        cfg_tari  = t;
        cfg_pulse = p;
        cfg_trcal = tr;
        cfg_data1 = d1;
    endtask

    // upper bound on the samples a task produces
    function automatic int burst_ticks(input logic [2:0] cmd, input logic bitv,
                                       input logic [TIMER_BITS-1:0] dur);
        case (cmd)
            CMD_TIMED:    return int'(dur);
            CMD_PREAMBLE: return cfg_delim + 2 * cfg_tari + cfg_data1 + cfg_trcal + 3 * cfg_pulse;
            CMD_FSYNC:    return cfg_delim + 2 * cfg_tari + cfg_data1 + 2 * cfg_pulse;
            CMD_DATA:     return (bitv ? cfg_data1 : cfg_tari) + cfg_pulse;
            default:      return $urandom_range(0, 3);
        endcase
    endfunction

    // mostly a task followed by the ticks that play it out, the rest noise
    task automatic run_random(input int budget);
        int                    stop;
        int                    ticks;
        logic                  op;
        logic [2:0]            cmd;
        logic                  bitv;
        logic [TIMER_BITS-1:0] dur;
        stop = sent + budget;
        while (sent < stop) begin
            bitv = 1'($urandom);
            if ($urandom_range(0, 3) != 0) begin
                cmd = 3'($urandom_range(int'(CMD_OFF), int'(CMD_DATA)));
                dur = (cmd == CMD_TIMED) ? TIMER_BITS'($urandom_range(0, TIMED_MAX))
                                         : TIMER_BITS'($urandom);
                push_request(OP_TASK, cmd, dur, bitv);
                ticks = burst_ticks(cmd, bitv, dur);
                if ($urandom_range(0, 7) == 0)
                    ticks = $urandom_range(0, ticks);
                push_ticks(ticks);
            end else begin
                op  = 1'($urandom);
                cmd = 3'($urandom);
                dur = (op == OP_TASK && cmd == CMD_TIMED)
                    ? TIMER_BITS'($urandom_range(0, TIMED_MAX)) : TIMER_BITS'($urandom);
                push_request(op, cmd, dur, bitv);
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        push_request(OP_TICK, CMD_OFF, '0, 1'b0);
        push_request(OP_TASK, CMD_ON, '1, 1'b1);
        push_request(OP_TICK, CMD_BAD_HI, '1, 1'b1);
        push_request(OP_TASK, CMD_OFF, '0, 1'b0);
        program_timing(2, 3, 1, 4, 5);
        push_request(OP_TASK, CMD_TIMED, TIMER_BITS'(2), 1'b0);
        push_request(OP_TASK, CMD_PREAMBLE, '0, 1'b0);
        push_ticks(3);
        push_request(OP_TASK, CMD_TIMED, '0, 1'b0);
        push_ticks(1);
        push_request(OP_TASK, CMD_BAD_LO, '0, 1'b0);
        push_request(OP_TASK, CMD_BAD_HI, '1, 1'b1);
        push_request(OP_TASK, CMD_DATA, '0, 1'b1);
        push_ticks(5);
        push_request(OP_TASK, CMD_DATA, '1, 1'b0);
        push_ticks(3);
        push_request(OP_TASK, CMD_FSYNC, '0, 1'b0);
        push_ticks(burst_ticks(CMD_FSYNC, 1'b0, '0));

        // random phases
        program_timing(3, 4, 1, 6, 7);
        run_random(300);
        program_timing(1, 1, 1, 1, 1);
        run_random(250);
        program_timing(2, 2, 5, 3, 4);
        run_random(250);
        program_timing(0, 0, 0, 0, 0);
        run_random(100);
        program_timing($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8),
                       $urandom_range(1, 8), $urandom_range(1, 8));
        run_random(300);
        program_timing(25, 25, 12, 100, 38);
        run_random(150);

        program_timing(4095, 4095, 4095, 4095, 4095);
        push_request(OP_TASK, CMD_ON, '0, 1'b0);
        push_ticks(2);
        push_request(OP_TASK, CMD_TIMED, TIMER_BITS'(3), 1'b0);
        push_ticks(4);
        push_request(OP_TASK, CMD_OFF, '0, 1'b0);
        push_ticks(1);

        // RTcal past the register width; the head of the frame is enough
        program_timing(1, 1, 1, 4095, 4095);
        push_request(OP_TASK, CMD_FSYNC, '0, 1'b0);
        push_ticks(12);

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("pie_symbol_burst_generator regression: pass");
        else
            $display("pie_symbol_burst_generator regression: fail");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("pie_symbol_burst_generator regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/psbg_pkg.sv
rtl/core/psbg_cfg.sv
rtl/core/psbg_core.sv
rtl/core/pie_symbol_burst_generator.sv
dv/pie_burst_checker.sv
dv/pie_symbol_burst_generator_tb.sv
